// ===== rtl/lsfe_pkg.sv =====
// Shared constants, codes and control structs for the LED strip frame encoder.
`timescale 1ns / 1ps

package lsfe_pkg;

   localparam int LED_COUNT    = 64;
   localparam int LED_IDX_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int LED_CNT_W    = $clog2(LED_COUNT + 1);
   localparam int COLOR_W      = 24;
   localparam int BITS_PER_LED = 24;
   localparam int WORD_W       = 16;
   localparam int SLOT_W       = 8;
   localparam int POS_W        = 10;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [POS_W:0]      LED_POS_LIMIT = (POS_W + 1)'(LED_COUNT);
   localparam logic [WORD_W-1:0]   SYM_ONE       = 16'hFFF0;
   localparam logic [WORD_W-1:0]   SYM_ZERO      = 16'hF000;
   localparam logic [WORD_W-1:0]   WORD_BLANK    = 16'h0000;
   localparam logic [SLOT_W-1:0]   SLOTS_RESET   = 8'd100;
   localparam logic [COLOR_W-1:0]  COLOR_RESET   = '0;

   typedef enum logic [1:0] {
      REQ_SET_ONE = 2'd0,
      REQ_SET_ALL = 2'd1,
      REQ_START   = 2'd2,
      REQ_TICK    = 2'd3
   } req_code_type;

   typedef enum logic {
      CSR_LEAD  = 1'b0,
      CSR_TRAIL = 1'b1
   } csr_reg_type;

   // store write command from the request sequencer
   typedef struct packed {
      logic                 we;
      logic                 all;
      logic [LED_IDX_W-1:0] idx;
      logic [COLOR_W-1:0]   color;
   } store_cmd_type;

   // frame sequencer operation for the current request
   typedef struct packed {
      logic start;
      logic tick;
      logic mark_dirty;
   } frame_op_type;

   typedef struct packed {
      logic [WORD_W-1:0] spi_word;
      logic              last_word;
   } rsp_beat_type;

   typedef struct packed {
      logic         valid;
      rsp_beat_type beat;
   } frame_res_type;

endpackage

// ===== rtl/lsfe_if.sv =====
// Valid/ready channel interfaces for request and response beats.
`timescale 1ns / 1ps

interface lsfe_req_if;
   logic                              valid;
   logic                              ready;
   lsfe_pkg::req_code_type            req_type;
   logic [lsfe_pkg::POS_W-1:0]        led_position;
   logic [7:0]                        red;
   logic [7:0]                        green;
   logic [7:0]                        blue;

   modport source (output valid, req_type, led_position, red, green, blue, input ready);
   modport sink   (input valid, req_type, led_position, red, green, blue, output ready);
endinterface

interface lsfe_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [lsfe_pkg::WORD_W-1:0]       spi_word;
   logic                              last_word;

   modport source (output valid, spi_word, last_word, input ready);
   modport sink   (input valid, spi_word, last_word, output ready);
endinterface

// ===== rtl/lsfe_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module lsfe_ram #(
   parameter int  WIDTH  = 24,
   parameter int  DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lsfe_store.sv =====
// Color store: RAM plus per-entry valid bits and a fill color for unwritten entries.
`timescale 1ns / 1ps

module lsfe_store (
   input  logic                           clock,
   input  logic                           reset,
   input  lsfe_pkg::store_cmd_type        cmd,
   input  logic [lsfe_pkg::LED_IDX_W-1:0] rd_idx,
   output logic [lsfe_pkg::COLOR_W-1:0]   rd_color
);

   logic [lsfe_pkg::LED_COUNT-1:0] valid_ff;
   logic [lsfe_pkg::COLOR_W-1:0]   fill_color_ff;
   logic                           hit_ff;
   logic [lsfe_pkg::COLOR_W-1:0]   ram_q;

   lsfe_ram #(
      .WIDTH (lsfe_pkg::COLOR_W),
      .DEPTH (lsfe_pkg::LED_COUNT)
   ) u_ram (
      .clock   (clock),
      .we      (cmd.we & ~cmd.all),
      .wr_addr (cmd.idx),
      .wr_data (cmd.color),
      .rd_addr (rd_idx),
      .rd_data (ram_q)
   );

   // set-all drops every valid bit and moves the color into the fill register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         fill_color_ff <= lsfe_pkg::COLOR_RESET;
      end else if (cmd.we) begin
         if (cmd.all) begin
            valid_ff      <= '0;
            fill_color_ff <= cmd.color;
         end else begin
            valid_ff[cmd.idx] <= 1'b1;
         end
      end
   end

   // sampled alongside the RAM read so both refer to the same edge
   always_ff @(posedge clock) begin
      hit_ff <= valid_ff[rd_idx];
   end

   assign rd_color = hit_ff ? ram_q : fill_color_ff;

endmodule

// ===== rtl/lsfe_frame.sv =====
// Frame sequencer: dirty mark, phase, slot and LED counters, SPI word selection.
`timescale 1ns / 1ps

module lsfe_frame (
   input  logic                           clock,
   input  logic                           reset,
   input  lsfe_pkg::frame_op_type         op,
   input  logic [lsfe_pkg::SLOT_W-1:0]    lead_slots,
   input  logic [lsfe_pkg::SLOT_W-1:0]    trail_slots,
   input  logic [lsfe_pkg::COLOR_W-1:0]   color,
   output logic [lsfe_pkg::LED_IDX_W-1:0] fill_idx,
   output lsfe_pkg::frame_res_type        res
);

   typedef enum logic [1:0] {
      PH_LEAD  = 2'd0,
      PH_DATA  = 2'd1,
      PH_CLOSE = 2'd2,
      PH_TRAIL = 2'd3
   } phase_type;

   localparam logic [4:0]                    TOP_BIT   = 5'(lsfe_pkg::BITS_PER_LED - 1);
   localparam logic [lsfe_pkg::SLOT_W-1:0]   BITS_LAST = lsfe_pkg::SLOT_W'(lsfe_pkg::BITS_PER_LED);
   localparam logic [lsfe_pkg::LED_CNT_W-1:0] FILL_END = lsfe_pkg::LED_CNT_W'(lsfe_pkg::LED_COUNT);

   logic                            active_ff, active_in;
   logic                            dirty_ff, dirty_in;
   phase_type                       phase_ff, phase_in;
   logic [lsfe_pkg::SLOT_W-1:0]     slot_ff, slot_in;
   logic [lsfe_pkg::LED_CNT_W-1:0]  fill_ff, fill_in;
   logic [4:0]                      bit_idx;

   always_comb begin
      active_in = active_ff;
      dirty_in  = dirty_ff;
      phase_in  = phase_ff;
      slot_in   = slot_ff;
      fill_in   = fill_ff;
      res       = '0;
      bit_idx   = TOP_BIT - slot_ff[4:0];

      if (op.mark_dirty) begin
         dirty_in = 1'b1;
      end

      if (op.start && !active_ff && dirty_ff) begin
         active_in = 1'b1;
         phase_in  = PH_LEAD;
         slot_in   = '0;
         fill_in   = '0;
      end

      if (op.tick && active_ff) begin
         res.valid = 1'b1;
         if (phase_in == PH_LEAD && slot_in >= lead_slots) begin
            phase_in = PH_DATA;
            slot_in  = '0;
            fill_in  = '0;
         end
         bit_idx = TOP_BIT - slot_in[4:0];
         case (phase_in)
            PH_LEAD: begin
               res.beat.spi_word = lsfe_pkg::WORD_BLANK;
               slot_in = slot_in + 1'b1;
            end
            PH_DATA: begin
               res.beat.spi_word = color[bit_idx] ? lsfe_pkg::SYM_ONE : lsfe_pkg::SYM_ZERO;
               slot_in = slot_in + 1'b1;
               if (slot_in == BITS_LAST) begin
                  slot_in = '0;
                  fill_in = fill_in + 1'b1;
                  if (fill_in == FILL_END) begin
                     phase_in = PH_CLOSE;
                  end
               end
            end
            PH_CLOSE: begin
               res.beat.spi_word = lsfe_pkg::SYM_ZERO;
               phase_in = PH_TRAIL;
               slot_in  = '0;
            end
            default: begin
               res.beat.spi_word = lsfe_pkg::WORD_BLANK;
               slot_in = slot_in + 1'b1;
            end
         endcase
         if (phase_in == PH_TRAIL && slot_in >= trail_slots) begin
            res.beat.last_word = 1'b1;
            active_in = 1'b0;
            dirty_in  = 1'b0;
            phase_in  = PH_LEAD;
            slot_in   = '0;
            fill_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         dirty_ff  <= 1'b1;
         phase_ff  <= PH_LEAD;
         slot_ff   <= '0;
         fill_ff   <= '0;
      end else begin
         active_ff <= active_in;
         dirty_ff  <= dirty_in;
         phase_ff  <= phase_in;
         slot_ff   <= slot_in;
         fill_ff   <= fill_in;
      end
   end

   assign fill_idx = fill_ff[lsfe_pkg::LED_IDX_W-1:0];

endmodule

// ===== rtl/lsfe_rsp_queue.sv =====
// Two-entry response queue driving the rsp channel.
`timescale 1ns / 1ps

module lsfe_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lsfe_pkg::rsp_beat_type push_beat,
   output logic                   room,
   lsfe_rsp_if.source             rsp_chan
);

   lsfe_pkg::rsp_beat_type entry_ff [2];
   logic                   wr_ptr_ff;
   logic                   rd_ptr_ff;
   logic [1:0]             count_ff;
   logic                   pop;

   assign pop = rsp_chan.valid & rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assign room               = (count_ff != 2'd2);
   assign rsp_chan.valid     = (count_ff != 2'd0);
   assign rsp_chan.spi_word  = entry_ff[rd_ptr_ff].spi_word;
   assign rsp_chan.last_word = entry_ff[rd_ptr_ff].last_word;

endmodule

// ===== rtl/rgb_led_strip_frame_encoder_top.sv =====
// Top level: APB registers, request sequencer, color store, frame sequencer, response queue.
`timescale 1ns / 1ps
// Each request beat is accepted in ST_IDLE, then executed in ST_EXEC, in which the
// color store's registered RAM read (issued at accept) is consumed. A tick's word
// enters the response queue at the end of the execute cycle. A new request is taken
// only in ST_IDLE and only while the two-entry response queue has room.
// Reset: lead/trail slots = 100, store reads all zero (valid bits cleared, no
// clearing pass), dirty mark set, no frame active, response queue empty.

module rgb_led_strip_frame_encoder_top (
   input  logic                            clock,
   input  logic                            reset,
   lsfe_req_if.sink                        req_chan,
   lsfe_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lsfe_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lsfe_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [lsfe_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      lsfe_pkg::req_code_type          code;
      logic [lsfe_pkg::POS_W-1:0]      pos;
      logic [7:0]                      red;
      logic [7:0]                      green;
      logic [7:0]                      blue;
   } req_beat_type;

   state_type                         state_ff, state_in;
   req_beat_type                      req_ff, req_in;
   logic [lsfe_pkg::SLOT_W-1:0]       lead_ff;
   logic [lsfe_pkg::SLOT_W-1:0]       trail_ff;

   logic                              accept;
   logic                              room;
   logic                              pos_ok;
   lsfe_pkg::store_cmd_type           store_cmd;
   lsfe_pkg::frame_op_type            frame_op;
   lsfe_pkg::frame_res_type           frame_res;
   logic [lsfe_pkg::LED_IDX_W-1:0]    fill_idx;
   logic [lsfe_pkg::COLOR_W-1:0]      color;
   logic                              csr_wr;

   // ---------------------------------------------------------------------------
   // APB register file; index is the word address, low byte bits are ignored
   // ---------------------------------------------------------------------------
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff  <= lsfe_pkg::SLOTS_RESET;
         trail_ff <= lsfe_pkg::SLOTS_RESET;
      end else if (csr_wr) begin
         case (lsfe_pkg::csr_reg_type'(paddr[2]))
            lsfe_pkg::CSR_LEAD:  lead_ff  <= pwdata[lsfe_pkg::SLOT_W-1:0];
            lsfe_pkg::CSR_TRAIL: trail_ff <= pwdata[lsfe_pkg::SLOT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (lsfe_pkg::csr_reg_type'(paddr[2]))
         lsfe_pkg::CSR_LEAD:  prdata = lsfe_pkg::CSR_DATA_W'(lead_ff);
         lsfe_pkg::CSR_TRAIL: prdata = lsfe_pkg::CSR_DATA_W'(trail_ff);
         default:             prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Request sequencer: one beat in flight. Beats are only taken while the
   // response queue has a free entry, so a tick's word always has a place.
   // ---------------------------------------------------------------------------
   assign req_chan.ready = (state_ff == ST_IDLE) & room;
   assign accept         = req_chan.valid & req_chan.ready;

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in     = ST_EXEC;
               req_in.code  = req_chan.req_type;
               req_in.pos   = req_chan.led_position;
               req_in.red   = req_chan.red;
               req_in.green = req_chan.green;
               req_in.blue  = req_chan.blue;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      req_ff <= req_in;
   end

   // ---------------------------------------------------------------------------
   // Execute-cycle decode
   // ---------------------------------------------------------------------------
   // out-of-range positions skip the store but still mark it dirty
   assign pos_ok = ({1'b0, req_ff.pos} < lsfe_pkg::LED_POS_LIMIT);

   always_comb begin
      store_cmd          = '0;
      frame_op           = '0;
      store_cmd.idx      = req_ff.pos[lsfe_pkg::LED_IDX_W-1:0];
      store_cmd.color    = {req_ff.green, req_ff.red, req_ff.blue};
      if (state_ff == ST_EXEC) begin
         case (req_ff.code)
            lsfe_pkg::REQ_SET_ONE: begin
               store_cmd.we        = pos_ok;
               frame_op.mark_dirty = 1'b1;
            end
            lsfe_pkg::REQ_SET_ALL: begin
               store_cmd.we        = 1'b1;
               store_cmd.all       = 1'b1;
               frame_op.mark_dirty = 1'b1;
            end
            lsfe_pkg::REQ_START: begin
               frame_op.start = 1'b1;
            end
            lsfe_pkg::REQ_TICK: begin
               frame_op.tick = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Store read address follows the LED pointer every cycle; the word for a
   // tick uses the read launched at its accept edge.
   lsfe_store u_store (
      .clock    (clock),
      .reset    (reset),
      .cmd      (store_cmd),
      .rd_idx   (fill_idx),
      .rd_color (color)
   );

   lsfe_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .op          (frame_op),
      .lead_slots  (lead_ff),
      .trail_slots (trail_ff),
      .color       (color),
      .fill_idx    (fill_idx),
      .res         (frame_res)
   );

   lsfe_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (frame_res.valid),
      .push_beat (frame_res.beat),
      .room      (room),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== dv/lsfe_frame_checker.sv =====
// Frame checker: mirrors the LED store and frame sequence and checks every response beat.
`timescale 1ns / 1ps

module lsfe_frame_checker
   import lsfe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   lsfe_req_if                   req_mon,
   lsfe_rsp_if                   rsp_mon,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic                  pready,
   output int unsigned           fail_count,
   output int unsigned           backlog,
   output logic                  frame_on
);

   typedef enum logic [1:0] {
      PART_LEAD,
      PART_DATA,
      PART_CLOSE,
      PART_TRAIL
   } frame_part_type;

   logic [COLOR_W-1:0] led_colors [LED_COUNT];
   logic               store_dirty;
   logic               frame_live;
   frame_part_type     frame_part;
   int unsigned        part_slot;
   int unsigned        led_ptr;
   logic [SLOT_W-1:0]  lead_len;
   logic [SLOT_W-1:0]  trail_len;
   rsp_beat_type       words_due [$];

   initial begin
      fail_count = 0;
      backlog    = 0;
      frame_on   = 1'b0;
   end

   function automatic void restart_strip();
      foreach (led_colors[i]) led_colors[i] = COLOR_RESET;
      store_dirty = 1'b1;
      frame_live  = 1'b0;
      frame_part  = PART_LEAD;
      part_slot   = 0;
      led_ptr     = 0;
      lead_len    = SLOTS_RESET;
      trail_len   = SLOTS_RESET;
      words_due.delete();
   endfunction

   // one accepted request; a tick inside a frame queues the word it must produce
   function automatic void strip_step(req_code_type kind, logic [POS_W-1:0] pos,
                                      logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      rsp_beat_type   beat;
      logic [COLOR_W-1:0] col;
      beat = '0;
      case (kind)
         REQ_SET_ONE: begin
            if (pos < LED_COUNT) led_colors[pos[LED_IDX_W-1:0]] = {green, red, blue};
            store_dirty = 1'b1;
         end
         REQ_SET_ALL: begin
            foreach (led_colors[i]) led_colors[i] = {green, red, blue};
            store_dirty = 1'b1;
         end
         REQ_START: begin
            if (!frame_live && store_dirty) begin
               frame_live = 1'b1;
               frame_part = PART_LEAD;
               part_slot  = 0;
               led_ptr    = 0;
            end
         end
         REQ_TICK: begin
            if (frame_live) begin
               if (frame_part == PART_LEAD && part_slot >= lead_len) begin
                  frame_part = PART_DATA;
                  part_slot  = 0;
                  led_ptr    = 0;
               end
               case (frame_part)
                  PART_LEAD: begin
                     beat.spi_word = WORD_BLANK;
                     part_slot++;
                  end
                  PART_DATA: begin
                     col = led_colors[led_ptr];
                     beat.spi_word = col[BITS_PER_LED - 1 - part_slot] ? SYM_ONE : SYM_ZERO;
                     part_slot++;
                     if (part_slot >= BITS_PER_LED) begin
                        part_slot = 0;
                        led_ptr++;
                        if (led_ptr >= LED_COUNT) frame_part = PART_CLOSE;
                     end
                  end
                  PART_CLOSE: begin
                     beat.spi_word = SYM_ZERO;
                     frame_part    = PART_TRAIL;
                     part_slot     = 0;
                  end
                  default: begin
                     beat.spi_word = WORD_BLANK;
                     part_slot++;
                  end
               endcase
               if (frame_part == PART_TRAIL && part_slot >= trail_len) begin
                  beat.last_word = 1'b1;
                  frame_live  = 1'b0;
                  store_dirty = 1'b0;
                  frame_part  = PART_LEAD;
                  part_slot   = 0;
                  led_ptr     = 0;
               end
               words_due.push_back(beat);
            end
         end
         default: ;
      endcase
   endfunction

   task automatic flag_mismatch(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      $display("%0t ns: %s mismatch, expected %h got %h", $time, what, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_beat_type want;
      if (reset) begin
         restart_strip();
      end else begin
         // response side first: a beat out now always belongs to an earlier tick
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (words_due.size() == 0) begin
               flag_mismatch("unexpected beat", WORD_BLANK, rsp_mon.spi_word);
            end else begin
               want = words_due.pop_front();
               if (rsp_mon.spi_word !== want.spi_word)
                  flag_mismatch("spi_word", want.spi_word, rsp_mon.spi_word);
               if (rsp_mon.last_word !== want.last_word)
                  flag_mismatch("last_word", WORD_W'(want.last_word),
                                WORD_W'(rsp_mon.last_word));
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (csr_reg_type'(paddr[CSR_ADDR_W-1:2]))
               CSR_LEAD:  lead_len  = pwdata[SLOT_W-1:0];
               CSR_TRAIL: trail_len = pwdata[SLOT_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            strip_step(req_mon.req_type, req_mon.led_position,
                       req_mon.red, req_mon.green, req_mon.blue);
      end
      backlog  <= words_due.size();
      frame_on <= frame_live;
   end

endmodule

// ===== dv/tb_rgb_led_strip_frame_encoder_top.sv =====
// Testbench top: clock, reset, request/CSR stimulus, response back-pressure and verdict.
`timescale 1ns / 1ps

module tb_rgb_led_strip_frame_encoder_top;
   import lsfe_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int SETTLE_CYCLES = 12;    // settle margin for the pipe
   localparam int QUIET_LIMIT   = 1000;  // cycles without any beat before giving up
   localparam int CALM_FROM     = 500;   // window with no idling on either side
   localparam int CALM_TO       = 900;
   localparam int WARM_ITEMS    = 40;    // random beats while still in the lead-in
   localparam int MAIN_ITEMS    = 490;   // random beats into the LED data

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int unsigned fail_count;
   int unsigned backlog;     // words predicted but not yet seen
   logic        frame_on;    // predicted frame in progress
   int unsigned cycle_no;
   int unsigned quiet_cycles;

   lsfe_req_if req_bus ();
   lsfe_rsp_if rsp_bus ();

   rgb_led_strip_frame_encoder_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   lsfe_frame_checker u_frame_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pready     (pready),
      .fail_count (fail_count),
      .backlog    (backlog),
      .frame_on   (frame_on)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // ~28% idle on each side, except inside the calm window
   function automatic bit take_break();
      if (cycle_no >= CALM_FROM && cycle_no < CALM_TO) return 1'b0;
      return $urandom_range(99) < 28;
   endfunction

   // response back-pressure, changed on the falling edge like every other input
   always @(negedge clock) begin
      rsp_bus.ready <= !take_break();
   end

   // watchdog: ends the run if nothing moves on any port for too long
   always @(posedge clock) begin
      cycle_no++;
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (psel && penable && pready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Called on a falling edge; returns on the falling edge after the beat is taken,
   // with valid still high so a back-to-back beat needs no second assignment.
   task automatic send_req(req_code_type kind, logic [POS_W-1:0] pos,
                           logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      while (take_break()) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.req_type     <= kind;
      req_bus.led_position <= pos;
      req_bus.red          <= red;
      req_bus.green        <= green;
      req_bus.blue         <= blue;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // color write: mostly in-range positions, some anywhere in the 10-bit field
   task automatic send_random_set();
      req_code_type     kind;
      logic [POS_W-1:0] pos;
      kind = ($urandom_range(9) == 0) ? REQ_SET_ALL : REQ_SET_ONE;
      pos  = ($urandom_range(5) == 0) ? POS_W'($urandom_range(1023))
                                      : POS_W'($urandom_range(LED_COUNT - 1));
      send_req(kind, pos, 8'($urandom()), 8'($urandom()), 8'($urandom()));
   endtask

   // any request type with any payload
   task automatic send_noise();
      send_req(req_code_type'($urandom_range(3)), POS_W'($urandom_range(1023)),
               8'($urandom()), 8'($urandom()), 8'($urandom()));
   endtask

   // hold the request side until every predicted word has come out
   task automatic drain_words();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (backlog != 0);
   endtask

   task automatic go_idle();
      drain_words();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // mostly ticks; color writes, stray starts and the odd full drain mixed in so
   // they land at every point of the frame; a new frame starts if none runs
   task automatic play_items(int unsigned count);
      int unsigned pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (!frame_on && pick < 20)
            send_req(REQ_START, POS_W'($urandom()), 8'($urandom()), 8'($urandom()),
                     8'($urandom()));
         else if (pick < 6)
            send_random_set();
         else if (pick == 6)
            send_req(REQ_START, POS_W'($urandom()), 8'($urandom()), 8'($urandom()),
                     8'($urandom()));
         else if (pick == 7)
            send_noise();
         else if (pick == 8)
            drain_words();
         else
            send_req(REQ_TICK, POS_W'($urandom()), 8'($urandom()), 8'($urandom()),
                     8'($urandom()));
      end
   endtask

   // two-phase APB write; upper data bits are random since only the low byte counts
   task automatic csr_write(csr_reg_type which, logic [SLOT_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({which, 2'b00});
      pwdata  <= {24'($urandom()), value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      reset                = 1'b1;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      req_bus.valid        = 1'b0;
      req_bus.req_type     = REQ_SET_ONE;
      req_bus.led_position = '0;
      req_bus.red          = '0;
      req_bus.green        = '0;
      req_bus.blue         = '0;
      rsp_bus.ready        = 1'b0;
      cycle_no             = 0;
      quiet_cycles         = 0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed part, default lead/trail of 100 ----
      // store is dirty out of reset, but a tick without a start gives nothing
      send_req(REQ_TICK, '0, 8'h00, 8'h00, 8'h00);
      send_req(REQ_SET_ALL, 10'h3FF, 8'h55, 8'hAA, 8'h0F);
      // corners of the store and of the color bytes
      send_req(REQ_SET_ONE, '0, 8'hFF, 8'hFF, 8'hFF);
      send_req(REQ_SET_ONE, POS_W'(LED_COUNT - 1), 8'h00, 8'h00, 8'h00);
      send_req(REQ_SET_ONE, POS_W'(LED_COUNT - 2), 8'h80, 8'h01, 8'hFE);
      // out-of-range positions: store untouched, dirty still set
      send_req(REQ_SET_ONE, POS_W'(LED_COUNT), 8'hFF, 8'hFF, 8'hFF);
      send_req(REQ_SET_ONE, 10'h3FF, 8'hFF, 8'hFF, 8'hFF);
      send_req(REQ_START, '0, 8'h00, 8'h00, 8'h00);
      // start while a frame runs is ignored
      send_req(REQ_START, 10'h155, 8'hA5, 8'h5A, 8'hC3);
      repeat (3) send_req(REQ_TICK, 10'h2AA, 8'h5A, 8'hA5, 8'h3C);
      // sender holds off until every word so far is out
      drain_words();
      // color change mid-frame shows up in words not yet sent
      send_req(REQ_SET_ONE, 10'd1, 8'hF0, 8'h0F, 8'h81);
      send_req(REQ_TICK, '0, 8'h00, 8'h00, 8'h00);

      // ---- random part ----
      play_items(WARM_ITEMS);
      go_idle();
      // a lead count already passed ends the lead-in at the next tick
      csr_write(CSR_LEAD, 8'd3);
      csr_write(CSR_TRAIL, 8'($urandom()));
      play_items(MAIN_ITEMS);
      go_idle();

      if (fail_count == 0 && backlog == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
